// ===== design/hkv_pkg.sv =====
// Shared constants and types for the hashed key/value cache.
`timescale 1ns / 1ps
package hkv_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned ADDR_W   = IDX_W + 1;
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned KEY_W    = 256;
  localparam int unsigned VAL_W    = 256;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY * 3 / 4 - 1);
  localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(CAPACITY - 1);

  localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME_LO = 64'h1b3;
  localparam int unsigned FNV_PRIME_SHIFT = 40;

  localparam logic [4:0] LAST_BYTE_MAP0 = 5'd23;
  localparam logic [4:0] LAST_BYTE_MAP1 = 5'd31;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  typedef struct packed {
    logic              rd;
    logic              wr_key;
    logic              wr_val;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W:0]    key_row;
    logic [VAL_W-1:0]  val_row;
  } hkv_mem_req_t;

endpackage

// ===== design/hashed_key_value_cache.sv =====
// Top level of the hashed key/value cache with its command sequencer.
`timescale 1ns / 1ps
// Two open-addressing hash tables, map 0 with three-word keys and map 1 with
// four, each slot holding a 256-bit value. A command word enters on the input
// channel (valid and stall) and one result word leaves on the output channel.
// One command is worked on at a time; in_stall_o is high while it runs.
// The home slot comes from a byte-serial FNV-1a unit. Each probed slot is then
// read on the key memory read port and checked, a lookup hit adds a value read,
// a store adds one write, and the result register is loaded last.
// A clear command sweeps the chosen map at one slot per cycle.
// After reset the block sweeps both maps before it takes a word.
// A finished result sits in the output register until taken; the next command
// is accepted meanwhile, and its own result waits if the receiver still stalls.
// A store of a new key into a map holding 767 keys is dropped with status 1.
module hashed_key_value_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic        which_map_i,
  input  logic [63:0] key_first_i,
  input  logic [63:0] key_second_i,
  input  logic [63:0] key_third_i,
  input  logic [63:0] key_fourth_i,
  input  logic [63:0] value_word0_i,
  input  logic [63:0] value_word1_i,
  input  logic [63:0] value_word2_i,
  input  logic [63:0] value_word3_i,
  input  logic [1:0]  word_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [63:0] value_word_o,
  output logic        status_o
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_CHK,
    S_WRITE, S_VAL_RD, S_VAL_CHK, S_CLEAR, S_DONE
  } state_e;

  localparam int unsigned IdxW  = hkv_pkg::IDX_W;
  localparam int unsigned AddrW = hkv_pkg::ADDR_W;
  localparam int unsigned CntW  = hkv_pkg::CNT_W;

  state_e                    state_q;
  logic [1:0]                cmd_q;
  logic                      mp_q;
  logic [hkv_pkg::KEY_W-1:0] key_q;
  logic [hkv_pkg::VAL_W-1:0] val_q;
  logic [1:0]                widx_q;
  logic [IdxW-1:0]           idx_q;
  logic [CntW-1:0]           pcnt_q;
  logic [AddrW-1:0]          ptr_q;
  logic                      hit_q;
  logic                      hash_start_q;
  logic                      res_found_q;
  logic [63:0]               res_word_q;
  logic                      res_status_q;
  logic                      out_valid_q;
  logic                      found_q;
  logic [63:0]               word_q;
  logic                      status_q;
  logic [CntW-1:0]           cnt_q [2];

  logic                      accept;
  logic                      hash_done;
  logic [IdxW-1:0]           hash_idx;
  hkv_pkg::hkv_mem_req_t     mem_req;
  logic [hkv_pkg::KEY_W:0]   key_row;
  logic [hkv_pkg::VAL_W-1:0] val_row;
  logic                      row_used;
  logic                      row_match;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign row_used  = key_row[hkv_pkg::KEY_W];
  assign row_match = (key_row[hkv_pkg::KEY_W-1:0] == key_q);

  hkv_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start_q),
    .map_i   (mp_q),
    .key_i   (key_q),
    .done_o  (hash_done),
    .index_o (hash_idx)
  );

  hkv_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .key_row_o (key_row),
    .val_row_o (val_row)
  );

  always_comb begin
    mem_req         = '0;
    mem_req.addr    = {mp_q, idx_q};
    mem_req.key_row = {1'b1, key_q};
    mem_req.val_row = val_q;
    case (state_q)
      S_INIT: begin
        mem_req.wr_key  = 1'b1;
        mem_req.addr    = ptr_q;
        mem_req.key_row = '0;
      end
      S_CLEAR: begin
        mem_req.wr_key  = 1'b1;
        mem_req.addr    = {mp_q, ptr_q[IdxW-1:0]};
        mem_req.key_row = '0;
      end
      S_PROBE_RD: mem_req.rd = 1'b1;
      S_VAL_RD:   mem_req.rd = 1'b1;
      S_WRITE: begin
        mem_req.wr_val = 1'b1;
        mem_req.wr_key = !hit_q;
      end
      default: mem_req.rd = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      ptr_q        <= '0;
      hash_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q[0]     <= '0;
      cnt_q[1]     <= '0;
    end else begin
      hash_start_q <= accept &&
                      (cmd_i == hkv_pkg::CMD_LOOKUP || cmd_i == hkv_pkg::CMD_STORE);
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          ptr_q <= ptr_q + AddrW'(1);
          if (ptr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_found_q  <= 1'b0;
            res_word_q   <= '0;
            res_status_q <= 1'b0;
            ptr_q        <= '0;
            if (cmd_i == hkv_pkg::CMD_LOOKUP || cmd_i == hkv_pkg::CMD_STORE) begin
              state_q <= S_HASH;
            end else if (cmd_i == hkv_pkg::CMD_CLEAR) begin
              state_q <= S_CLEAR;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx_q   <= hash_idx;
            pcnt_q  <= '0;
            state_q <= S_PROBE_RD;
          end
        end
        S_PROBE_RD: state_q <= S_PROBE_CHK;
        S_PROBE_CHK: begin
          if (!row_used || row_match) begin
            hit_q       <= row_used;
            res_found_q <= row_used;
            if (cmd_q == hkv_pkg::CMD_LOOKUP) begin
              state_q <= row_used ? S_VAL_RD : S_DONE;
            end else if (!row_used && cnt_q[mp_q] >= hkv_pkg::FULL_CNT) begin
              res_status_q <= 1'b1;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_WRITE;
            end
          end else if (pcnt_q == hkv_pkg::LAST_PROBE) begin
            if (cmd_q == hkv_pkg::CMD_STORE) begin
              res_status_q <= 1'b1;
            end
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            pcnt_q  <= pcnt_q + CntW'(1);
            state_q <= S_PROBE_RD;
          end
        end
        S_WRITE: begin
          if (!hit_q) begin
            cnt_q[mp_q] <= cnt_q[mp_q] + CntW'(1);
          end
          state_q <= S_DONE;
        end
        S_VAL_RD: state_q <= S_VAL_CHK;
        S_VAL_CHK: begin
          res_word_q <= val_row[{widx_q, 6'd0} +: 64];
          state_q    <= S_DONE;
        end
        S_CLEAR: begin
          ptr_q <= ptr_q + AddrW'(1);
          if (ptr_q[IdxW-1:0] == IdxW'(hkv_pkg::CAPACITY - 1)) begin
            cnt_q[mp_q] <= '0;
            state_q     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            found_q     <= res_found_q;
            word_q      <= res_word_q;
            status_q    <= res_status_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      mp_q   <= which_map_i;
      key_q  <= {which_map_i ? key_fourth_i : 64'd0, key_third_i, key_second_i, key_first_i};
      val_q  <= {value_word3_i, value_word2_i, value_word1_i, value_word0_i};
      widx_q <= word_index_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign value_word_o = word_q;
  assign status_o     = status_q;

  a_status_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(status_o && found_o)) else $error("full status on a present key");

  a_word_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && value_word_o != 64'd0) |-> found_o) else $error("value without hit");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= hkv_pkg::FULL_CNT) && (cnt_q[1] <= hkv_pkg::FULL_CNT))
    else $error("entry count over load limit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o) else $error("second word taken while busy");

endmodule

// ===== design/hkv_hash.sv =====
// Byte-serial FNV-1a 64 hash unit that yields the home slot index.
`timescale 1ns / 1ps
module hkv_hash (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            map_i,
  input  logic [hkv_pkg::KEY_W-1:0]       key_i,
  output logic                            done_o,
  output logic [hkv_pkg::IDX_W-1:0]       index_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [4:0]                  cnt_q;
  logic [4:0]                  last_q;
  logic [63:0]                 h_q;
  logic [hkv_pkg::KEY_W-1:0]   key_q;
  logic [63:0]                 h_x;
  logic [63:0]                 h_d;

  assign h_x = h_q ^ {56'd0, key_q[{cnt_q, 3'b000} +: 8]};
  assign h_d = (h_x << hkv_pkg::FNV_PRIME_SHIFT) + 64'(h_x * hkv_pkg::FNV_PRIME_LO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      last_q <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == last_q);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        last_q <= map_i ? hkv_pkg::LAST_BYTE_MAP1 : hkv_pkg::LAST_BYTE_MAP0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == last_q) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q   <= hkv_pkg::FNV_OFFSET;
      key_q <= key_i;
    end else if (busy_q) begin
      h_q <= h_d;
    end
  end

  assign done_o  = done_q;
  assign index_o = h_q[hkv_pkg::IDX_W-1:0];

endmodule

// ===== design/hkv_store.sv =====
// Key and value memories with registered read data.
`timescale 1ns / 1ps
module hkv_store (
  input  logic                          clk_i,
  input  hkv_pkg::hkv_mem_req_t         req_i,
  output logic [hkv_pkg::KEY_W:0]       key_row_o,
  output logic [hkv_pkg::VAL_W-1:0]     val_row_o
);

  localparam int unsigned Depth = 2 * hkv_pkg::CAPACITY;

  logic [hkv_pkg::KEY_W:0]   key_mem [Depth];
  logic [hkv_pkg::VAL_W-1:0] val_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_key) begin
      key_mem[req_i.addr] <= req_i.key_row;
    end
    if (req_i.rd) begin
      key_row_o <= key_mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_val) begin
      val_mem[req_i.addr] <= req_i.val_row;
    end
    if (req_i.rd) begin
      val_row_o <= val_mem[req_i.addr];
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the hashed key/value cache with a predicting scoreboard.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned SLOT_CNT = hkv_pkg::CAPACITY;
  localparam int unsigned WATCH_LIMIT = 60000;

  typedef struct {
    logic        found;
    logic [63:0] value_word;
    logic        status;
  } cache_answer_t;

  class cache_scoreboard;
    logic [63:0]   key_mem[2][SLOT_CNT][4];
    logic [63:0]   val_mem[2][SLOT_CNT][4];
    bit            used[2][SLOT_CNT];
    int unsigned   fill[2];
    cache_answer_t pending[$];
    int unsigned   errors;

    function void clear_all();
      used = '{default: 0};
      fill = '{0, 0};
    endfunction

    function logic [63:0] fnv_hash(logic [63:0] kw[4], int unsigned nwords);
      logic [63:0] h;
      h = 64'hcbf29ce484222325;
      for (int i = 0; i < nwords; i++)
        for (int b = 0; b < 8; b++) begin
          h = h ^ {56'd0, kw[i][8*b +: 8]};
          h = h * 64'h100000001b3;
        end
      return h;
    endfunction

    function bit find_slot(int mp, logic [63:0] kw[4], int unsigned nwords,
                           output int unsigned slot);
      int unsigned idx;
      bit same;
      idx = 32'(fnv_hash(kw, nwords)) & (SLOT_CNT - 1);
      for (int t = 0; t < SLOT_CNT; t++) begin
        if (!used[mp][idx]) begin
          slot = idx;
          return 0;
        end
        same = 1;
        for (int i = 0; i < nwords; i++)
          if (key_mem[mp][idx][i] !== kw[i]) same = 0;
        if (same) begin
          slot = idx;
          return 1;
        end
        idx = (idx + 1) & (SLOT_CNT - 1);
      end
      slot = SLOT_CNT;
      return 0;
    endfunction

    function void note_command(logic [1:0] cmd, logic mp, logic [63:0] kw_in[4],
                               logic [63:0] vw[4], logic [1:0] widx);
      cache_answer_t a;
      logic [63:0] kw[4];
      int unsigned slot, nw;
      bit hit;
      a = '{0, 64'd0, 0};
      kw = kw_in;
      if (!mp) kw[3] = 64'd0;
      nw = mp ? 4 : 3;
      case (cmd)
        hkv_pkg::CMD_LOOKUP: begin
          if (find_slot(mp, kw, nw, slot)) begin
            a.found = 1;
            a.value_word = val_mem[mp][slot][widx];
          end
        end
        hkv_pkg::CMD_STORE: begin
          hit = find_slot(mp, kw, nw, slot);
          a.found = hit;
          if (!hit) begin
            if ((fill[mp] + 1) * 4 >= SLOT_CNT * 3 || slot >= SLOT_CNT) a.status = 1;
            else begin
              for (int i = 0; i < 4; i++) key_mem[mp][slot][i] = kw[i];
              used[mp][slot] = 1;
              fill[mp]++;
            end
          end
          if (!a.status)
            for (int i = 0; i < 4; i++) val_mem[mp][slot][i] = vw[i];
        end
        hkv_pkg::CMD_CLEAR: begin
          for (int s = 0; s < SLOT_CNT; s++) used[mp][s] = 0;
          fill[mp] = 0;
        end
        default: ;
      endcase
      pending.push_back(a);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_answer(logic f, logic [63:0] w, logic s);
      cache_answer_t e;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (f !== e.found)
        report_mismatch($sformatf("found %0b, expected %0b", f, e.found));
      if (w !== e.value_word)
        report_mismatch($sformatf("value_word %h, expected %h", w, e.value_word));
      if (s !== e.status)
        report_mismatch($sformatf("status %0b, expected %0b", s, e.status));
    endtask
  endclass

  logic        clk_i = 0, rst_ni = 0;
  logic        in_valid_i = 0, out_stall_i = 0;
  logic        in_stall_o, out_valid_o, found_o, status_o;
  logic [1:0]  cmd_i = '0, word_index_i = '0;
  logic        which_map_i = 0;
  logic [63:0] key_first_i = '0, key_second_i = '0, key_third_i = '0, key_fourth_i = '0;
  logic [63:0] value_word0_i = '0, value_word1_i = '0, value_word2_i = '0;
  logic [63:0] value_word3_i = '0, value_word_o;

  hashed_key_value_cache uut (.*);

  cache_scoreboard board;
  int unsigned send_idle_pct, recv_idle_pct, quiet_cycles;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_answer(found_o, value_word_o, status_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("** hashed_key_value_cache: FAILED **");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] cmd, logic mp, logic [63:0] kw[4],
                           logic [63:0] vw[4], logic [1:0] widx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    cmd_i <= cmd;
    which_map_i <= mp;
    key_first_i <= kw[0];
    key_second_i <= kw[1];
    key_third_i <= kw[2];
    key_fourth_i <= kw[3];
    value_word0_i <= vw[0];
    value_word1_i <= vw[1];
    value_word2_i <= vw[2];
    value_word3_i <= vw[3];
    word_index_i <= widx;
    do @(posedge clk_i); while (in_stall_o);
    board.note_command(cmd, mp, kw, vw, widx);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_random(int unsigned pool);
    logic [63:0] kw[4], vw[4];
    logic [1:0] cmd;
    logic mp;
    int unsigned r, base;
    r = $urandom_range(999);
    mp = 1'($urandom_range(1));
    cmd = (r < 2) ? hkv_pkg::CMD_CLEAR : (r < 6) ? hkv_pkg::CMD_NOP :
          (r < 500) ? hkv_pkg::CMD_STORE : hkv_pkg::CMD_LOOKUP;
    for (int i = 0; i < 4; i++) vw[i] = rand64();
    base = $urandom_range(pool - 1);
    if ($urandom_range(9) < 8) begin
      kw[0] = 64'(base);
      kw[1] = 64'hA5A5_0000_0000_0000 ^ 64'(base);
      kw[2] = (base % 7 == 0) ? '1 : 64'd0;
      kw[3] = 64'(base & 1);
    end else
      for (int i = 0; i < 4; i++) kw[i] = rand64();
    send_word(cmd, mp, kw, vw, 2'($urandom_range(3)));
  endtask

  task automatic send_plain(logic [1:0] cmd, logic mp, logic [63:0] k0, logic [63:0] k3,
                            logic [63:0] v, logic [1:0] widx);
    logic [63:0] kw[4], vw[4];
    kw = '{k0, ~k0, k0 ^ 64'h55, k3};
    vw = '{v, ~v, v ^ 64'hFF, {v[31:0], v[63:32]}};
    send_word(cmd, mp, kw, vw, widx);
  endtask

  initial begin
    board = new();
    board.clear_all();
    board.errors = 0;
    quiet_cycles = 0;
    send_idle_pct = 38;
    recv_idle_pct = 81;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_plain(hkv_pkg::CMD_LOOKUP, 0, 64'd0, 64'd0, 64'd0, 2'd0);
    send_plain(hkv_pkg::CMD_STORE, 0, 64'd0, 64'd0, '1, 2'd0);
    send_plain(hkv_pkg::CMD_STORE, 0, 64'd0, 64'hDEAD, 64'h1234, 2'd0);
    for (int w = 0; w < 4; w++) send_plain(hkv_pkg::CMD_LOOKUP, 0, 64'd0, '1, 64'd0, w[1:0]);
    send_plain(hkv_pkg::CMD_STORE, 1, '1, '1, 64'h8000_0000_0000_0001, 2'd0);
    send_plain(hkv_pkg::CMD_LOOKUP, 1, '1, '1, 64'd0, 2'd3);
    send_plain(hkv_pkg::CMD_LOOKUP, 1, '1, 64'd0, 64'd0, 2'd3);
    send_plain(hkv_pkg::CMD_NOP, 1, '1, '1, '1, 2'd3);
    send_plain(hkv_pkg::CMD_CLEAR, 1, '1, '1, '1, 2'd1);
    send_plain(hkv_pkg::CMD_LOOKUP, 1, '1, '1, 64'd0, 2'd0);
    send_plain(hkv_pkg::CMD_LOOKUP, 0, 64'd0, 64'd0, 64'd0, 2'd2);
    send_plain(hkv_pkg::CMD_CLEAR, 0, 64'd0, 64'd0, 64'd0, 2'd0);
    send_plain(hkv_pkg::CMD_LOOKUP, 0, 64'd0, 64'd0, 64'd0, 2'd0);

    // Fill map 0 to the load limit so the drop with full status is reached.
    for (int i = 0; i < 770; i++)
      send_plain(hkv_pkg::CMD_STORE, 0, 64'(i), 64'd0, 64'(i * 3), 2'd0);
    send_plain(hkv_pkg::CMD_STORE, 0, 64'd5, 64'd0, 64'h77, 2'd0);
    send_plain(hkv_pkg::CMD_LOOKUP, 0, 64'd5, 64'd0, 64'd0, 2'd0);
    send_plain(hkv_pkg::CMD_LOOKUP, 0, 64'd769, 64'd0, 64'd0, 2'd0);
    send_plain(hkv_pkg::CMD_CLEAR, 0, 64'd0, 64'd0, 64'd0, 2'd0);

    for (int i = 0; i < 160; i++) begin
      if (i == 0) begin
        send_idle_pct = 81;
        recv_idle_pct = 38;
      end else if (i == 80) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random((i % 3 == 0) ? 900 : 64);
    end
    in_valid_i <= 0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) $display("** hashed_key_value_cache: PASSED **");
    else $display("** hashed_key_value_cache: FAILED **");
    $finish;
  end
endmodule

// ===== hashed_key_value_cache.f =====
design/hkv_pkg.sv
design/hkv_hash.sv
design/hkv_store.sv
design/hashed_key_value_cache.sv
tb/sv/tb_top.sv
